FILE: rtl/page_framebuffer_bitmap_blit_core_defines.svh
// Assertion macros used by the framebuffer blit controller.
`ifndef PAGE_FRAMEBUFFER_BITMAP_BLIT_CORE_DEFINES_SVH
`define PAGE_FRAMEBUFFER_BITMAP_BLIT_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define PFB_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("pfb_blit assertion failed");
// Condition must never be true outside reset.
`define PFB_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `PFB_ASSERT(lbl, clk, rst_n, !(cond))
`else
`define PFB_ASSERT(lbl, clk, rst_n, prop)
`define PFB_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

FILE: rtl/pfb_blit_pkg.sv
// Types, constants and request codes for the framebuffer blit block.
package pfb_blit_pkg;

  localparam int unsigned DISPLAY_COLUMNS  = 128;
  localparam int unsigned MAX_DISPLAY_ROWS = 64;
  localparam int unsigned STORE_DEPTH      = 1024;
  localparam int unsigned STORE_AW         = $clog2(STORE_DEPTH);
  localparam int unsigned ROWS_W           = 7;
  localparam logic [ROWS_W-1:0] ROWS_RESET = 7'd64;

  typedef enum logic [1:0] {
    REQ_DRAW  = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_READ  = 2'd2,
    REQ_RSVD  = 2'd3
  } req_type_e;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [7:0]          bmp_bits;
    logic [7:0]          bmp_width;
    logic [7:0]          bmp_height;
    logic [7:0]          origin_x;
    logic [7:0]          origin_y;
    logic [7:0]          src_row;
    logic [4:0]          bmp_byte_idx;
    logic [STORE_AW-1:0] read_addr;
  } blit_req_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] pixels_written;
    logic [7:0] read_data;
  } blit_rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic                capture;
    logic                rd_en;
    logic                rd_item;
    logic [2:0]          k;
    logic                wb_en;
    logic                clr_en;
    logic [STORE_AW-1:0] clr_addr;
    logic                res_load;
  } blit_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [1:0] req_type;
    logic       size_ok;
    logic [3:0] pix_cnt;
  } blit_sts_t;

endpackage

FILE: rtl/pfb_blit_dpath.sv
// Datapath: item capture, clipping and address math, frame store, result register.
module pfb_blit_dpath #(
  parameter int unsigned DisplayColumns = pfb_blit_pkg::DISPLAY_COLUMNS,
  parameter int unsigned MaxDisplayRows = pfb_blit_pkg::MAX_DISPLAY_ROWS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pfb_blit_pkg::ROWS_W-1:0]     cfg_wdata_i,
  input  pfb_blit_pkg::blit_req_t             req_i,
  input  pfb_blit_pkg::blit_cmd_t             cmd_i,
  output pfb_blit_pkg::blit_sts_t             sts_o,
  output pfb_blit_pkg::blit_rsp_t             rsp_o
);
  import pfb_blit_pkg::*;

  localparam logic [8:0]        Cols    = 9'(DisplayColumns);
  localparam logic [ROWS_W-1:0] MaxRows = ROWS_W'(MaxDisplayRows);

  logic [ROWS_W-1:0]   rows_q;
  blit_req_t           item_q;
  logic [7:0]          mem [STORE_DEPTH];
  logic [7:0]          rd_data_q;
  logic [STORE_AW-1:0] wb_addr_q;
  logic                wb_bit_q;
  blit_rsp_t           rsp_q;
  blit_rsp_t           rsp_d;

  logic [ROWS_W-1:0]   rows_eff;
  logic [8:0]          rows9, ox9, oy9, w9, h9, row9, xs9;
  logic [8:0]          dw9, dh9, rem9, y9;
  logic                off_panel, row_ok, size_ok, is_draw;
  logic [3:0]          n_bits, pix_cnt;
  logic [7:0]          mask;
  logic [15:0]         base16;
  logic [STORE_AW-1:0] draw_addr, rd_addr;
  logic                mem_we;
  logic [STORE_AW-1:0] mem_waddr;
  logic [7:0]          mem_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ROWS_RESET;
    end else if (cfg_we_i) begin
      rows_q <= cfg_wdata_i;
    end
  end

  // Clip the bitmap against the panel.
  always_comb begin
    rows_eff  = (rows_q > MaxRows) ? MaxRows : rows_q;
    rows9     = 9'(rows_eff);
    ox9       = {1'b0, item_q.origin_x};
    oy9       = {1'b0, item_q.origin_y};
    w9        = {1'b0, item_q.bmp_width};
    h9        = {1'b0, item_q.bmp_height};
    row9      = {1'b0, item_q.src_row};
    xs9       = {1'b0, item_q.bmp_byte_idx, 3'b000};
    off_panel = (ox9 >= Cols) || (oy9 >= rows9);
    dw9       = ((ox9 + w9) > Cols) ? (Cols - ox9) : w9;
    dh9       = ((oy9 + h9) > rows9) ? (rows9 - oy9) : h9;
    row_ok    = row9 < dh9;
    rem9      = dw9 - xs9;
    if (xs9 >= dw9) begin
      n_bits = 4'd0;
    end else if (rem9 > 9'd8) begin
      n_bits = 4'd8;
    end else begin
      n_bits = rem9[3:0];
    end
    pix_cnt   = (!off_panel && row_ok) ? n_bits : 4'd0;
    size_ok   = (item_q.bmp_width != 8'd0) && (item_q.bmp_height != 8'd0);
    y9        = oy9 + row9;
    mask      = 8'd1 << y9[2:0];
    base16    = 16'(y9[8:3]) * 16'(Cols) + 16'(ox9) + 16'(xs9);
    draw_addr = STORE_AW'(base16 + 16'(cmd_i.k));
    rd_addr   = cmd_i.rd_item ? item_q.read_addr : draw_addr;
  end

  assign sts_o.req_type = item_q.req_type;
  assign sts_o.size_ok  = size_ok;
  assign sts_o.pix_cnt  = pix_cnt;

  // Write port: clearing sweep or pixel write-back.
  assign mem_we    = cmd_i.clr_en | cmd_i.wb_en;
  assign mem_waddr = cmd_i.clr_en ? cmd_i.clr_addr : wb_addr_q;
  assign mem_wdata = cmd_i.clr_en ? 8'd0
                   : (wb_bit_q ? (rd_data_q | mask) : (rd_data_q & ~mask));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Hold the item, the pending write-back target and the result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= req_i;
    end
    if (cmd_i.rd_en) begin
      wb_addr_q <= rd_addr;
      wb_bit_q  <= item_q.bmp_bits[cmd_i.k];
    end
    if (cmd_i.res_load) begin
      rsp_q <= rsp_d;
    end
  end

  always_comb begin
    is_draw              = (item_q.req_type == REQ_DRAW) && size_ok;
    rsp_d.ok             = is_draw || (item_q.req_type == REQ_CLEAR)
                         || (item_q.req_type == REQ_READ);
    rsp_d.pixels_written = is_draw ? pix_cnt : 4'd0;
    rsp_d.read_data      = (item_q.req_type == REQ_READ) ? rd_data_q : 8'd0;
  end

  assign rsp_o = rsp_q;

endmodule

FILE: rtl/pfb_blit_ctrl.sv
// Controller: sequences store clearing, pixel read-modify-write and results.
`include "page_framebuffer_bitmap_blit_core_defines.svh"
module pfb_blit_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  output logic                    done_o,
  input  pfb_blit_pkg::blit_sts_t sts_i,
  output pfb_blit_pkg::blit_cmd_t cmd_o
);
  import pfb_blit_pkg::*;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_RMW,
    S_DRAIN,
    S_CLEAR,
    S_READ,
    S_RESP
  } state_e;

  state_e              state_q;
  logic [STORE_AW-1:0] cnt_q;
  logic [2:0]          k_q;
  logic                done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      cnt_q   <= '0;
      k_q     <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_INIT: begin
          cnt_q <= cnt_q + 1'b1;
          if (&cnt_q) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (start) state_q <= S_DECODE;
        end
        S_DECODE: begin
          case (sts_i.req_type)
            REQ_DRAW: begin
              k_q <= '0;
              if (sts_i.size_ok && (sts_i.pix_cnt != 4'd0)) begin
                state_q <= S_RMW;
              end else begin
                state_q <= S_RESP;
              end
            end
            REQ_CLEAR: begin
              cnt_q   <= '0;
              state_q <= S_CLEAR;
            end
            REQ_READ: state_q <= S_READ;
            default:  state_q <= S_RESP;
          endcase
        end
        S_RMW: begin
          k_q <= k_q + 1'b1;
          if ((4'(k_q) + 4'd1) == sts_i.pix_cnt) state_q <= S_DRAIN;
        end
        S_DRAIN: state_q <= S_RESP;
        S_CLEAR: begin
          cnt_q <= cnt_q + 1'b1;
          if (&cnt_q) state_q <= S_RESP;
        end
        S_READ: state_q <= S_RESP;
        S_RESP: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.capture  = (state_q == S_IDLE) && start;
    // Issue a pixel read each cycle; write back the previous one behind it.
    cmd_o.rd_en    = (state_q == S_RMW)
                   || ((state_q == S_DECODE) && (sts_i.req_type == REQ_READ));
    cmd_o.rd_item  = (state_q == S_DECODE);
    cmd_o.k        = k_q;
    cmd_o.wb_en    = ((state_q == S_RMW) && (k_q != 3'd0)) || (state_q == S_DRAIN);
    cmd_o.clr_en   = (state_q == S_INIT) || (state_q == S_CLEAR);
    cmd_o.clr_addr = cnt_q;
    cmd_o.res_load = (state_q == S_RESP);
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

  `PFB_ASSERT(a_wb_after_rd, clk_i, rst_ni, cmd_o.wb_en |-> $past(cmd_o.rd_en))
  `PFB_ASSERT(a_k_in_range, clk_i, rst_ni, (state_q == S_RMW) |-> (4'(k_q) < sts_i.pix_cnt))
  `PFB_ASSERT(a_done_after_resp, clk_i, rst_ni, done_o |-> $past(state_q == S_RESP))
  `PFB_ASSERT_NEVER(a_clr_rd_overlap, clk_i, rst_ni, cmd_o.clr_en && cmd_o.rd_en)

endmodule

FILE: rtl/page_framebuffer_bitmap_blit_core.sv
// Page-organized monochrome framebuffer with a clipped bitmap byte blit.
//
// Usage: an item on req_i is transferred at a rising edge with start high and
// busy low. Each item yields one result on rsp_o, marked by a one-cycle
// done_o pulse; the receiver must take it then, it cannot stall the block.
// The panel height register is written through cfg_we_i/cfg_wdata_i only
// while the block is idle, a rule for the user: the block itself does not
// enforce it. The register resets to 64 rows. After transfer an item passes
// a decode state; then a draw that updates n pixels (n from 1 to 8) runs one
// pixel read-modify-write per cycle, overlapped read and write-back, and a
// drain state, a read a read state, and a clear a sweep of the 1024-byte
// store through its single write port; a draw that updates nothing and a
// reserved or rejected item go on directly. Each item ends in a response
// state that loads the result. A new item may be transferred in the cycle
// that done_o is high. After reset the store is zeroed by a sweep over all
// 1024 bytes, one byte per cycle; busy stays high until it ends.
module page_framebuffer_bitmap_blit_core #(
  parameter int unsigned DisplayColumns = pfb_blit_pkg::DISPLAY_COLUMNS,
  parameter int unsigned MaxDisplayRows = pfb_blit_pkg::MAX_DISPLAY_ROWS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  pfb_blit_pkg::blit_req_t         req_i,
  output logic                            done_o,
  output pfb_blit_pkg::blit_rsp_t         rsp_o,
  input  logic                            cfg_we_i,
  input  logic [pfb_blit_pkg::ROWS_W-1:0] cfg_wdata_i
);
  import pfb_blit_pkg::*;

  blit_cmd_t cmd;
  blit_sts_t sts;

  pfb_blit_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  pfb_blit_dpath #(
    .DisplayColumns (DisplayColumns),
    .MaxDisplayRows (MaxDisplayRows)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_o       (rsp_o)
  );

endmodule
